@@ design/wheel_tachometer_odometer_macros.svh @@
// Assertion macros shared by the wheel tachometer / odometer RTL.
// Included by every module that carries concurrent assertions.
// Bodies are empty when SYNTHESIS is defined.
`ifndef WHEEL_TACHOMETER_ODOMETER_MACROS_SVH
`define WHEEL_TACHOMETER_ODOMETER_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, disabled while reset is low
`define WTO_ASSERT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wto assertion failed");
// next-cycle implication, disabled while reset is low
`define WTO_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wto assertion failed");
`else
`define WTO_ASSERT(label, clk, rst_n, ante, cons)
`define WTO_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ design/wto_pkg.sv @@
// Constants and codes for the wheel tachometer / odometer.
// No dependencies; used by wheel_tachometer_odometer.
package wto_pkg;

    // input kind, carried on tuser
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_PULSE = 1'b1;

    // configuration register indexes
    localparam logic REG_DIAMETER = 1'b0;
    localparam logic REG_START_KM = 1'b1;

    localparam logic [18:0] RPM_NUM       = 19'd300000;
    localparam logic [18:0] RPM_MAX       = 19'd300000;
    localparam logic [15:0] SPEED_NUM     = 16'd56547;
    localparam logic [6:0]  SPEED_DEN_MUL = 7'd100;
    localparam logic [16:0] SPEED_MAX     = 17'd113094;
    localparam logic [14:0] CIRC_NUM      = 15'd31415;
    localparam logic [13:0] CIRC_DEN      = 14'd10000;
    localparam logic [7:0]  DIAM_MAX      = 8'd200;

    // distance is kept as km quotient and cm remainder
    localparam logic [16:0] CM_PER_KM     = 17'd100000;
    // 2**48 cm = KM_WRAP_Q km + KM_WRAP_R cm
    localparam logic [31:0] KM_WRAP_Q     = 32'd2814749767;
    localparam logic [16:0] KM_WRAP_R     = 17'd10656;
    localparam logic [16:0] KM_WRAP_ADJ   = 17'd89344;

    // sample*255/1023 == sample*85/341
    localparam logic [6:0]  DUTY_NUM      = 7'd85;
    localparam logic [8:0]  DUTY_DEN      = 9'd341;
    // floor(v/10) == (v*205) >> 11 for v below 1024
    localparam logic [7:0]  DIV10_MUL     = 8'd205;
    localparam int          DIV10_SHIFT   = 11;

    localparam logic [14:0] OBST_DERATE   = 15'd300;
    localparam logic [16:0] SPEED_DERATE  = 17'd20;
    localparam logic [14:0] OBST_WARN     = 15'd100;

endpackage

@@ design/wto_sdiv.sv @@
// Bit-serial restoring divider: one quotient bit per clock for an N_W-bit quotient.
// Depends on wheel_tachometer_odometer_macros.svh for assertions.
`include "wheel_tachometer_odometer_macros.svh"

module wto_sdiv #(
    parameter int N_W = 24,
    parameter int D_W = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [N_W-1:0] i_dividend,
    input  logic [D_W-1:0] i_divisor,
    output logic           o_busy,
    output logic [N_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(N_W + 1);

    logic [D_W-1:0]   r_rem;
    logic [D_W-1:0]   r_den;
    logic [N_W-1:0]   r_quo;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;

    logic [D_W:0]     w_trial;
    logic [D_W:0]     w_diff;
    logic             w_ge;

    // shift the next dividend bit into the partial remainder
    assign w_trial = {r_rem, r_quo[N_W-1]};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign w_ge    = (w_trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(N_W);
            r_rem  <= '0;
            r_quo  <= i_dividend;
            r_den  <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[D_W-1:0] : w_trial[D_W-1:0];
            r_quo <= {r_quo[N_W-2:0], w_ge};
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

    `WTO_ASSERT(a_no_restart, i_clk, i_rst_n, i_start, !r_busy)
    `WTO_ASSERT_NEXT(a_finish, i_clk, i_rst_n, r_busy && r_cnt == CNT_W'(1), !r_busy)

endmodule

@@ design/wheel_tachometer_odometer.sv @@
// Wheel tachometer and odometer with collision-aware throttle duty.
// Depends on wto_pkg, wto_sdiv and wheel_tachometer_odometer_macros.svh.
//
// Usage:
//   Input stream (s_axis_*): tuser = 0 is a millisecond tick, tuser = 1 a
//   wheel revolution pulse carrying obstacle distance and pedal sample.
//   A tick is taken while idle and gives no result. A pulse gives one
//   result on the output stream (m_axis_*) after the states S_PREP, S_DIV,
//   S_UPD, S_WRAP and S_OUT; the next input is taken when that result is in
//   the output register. S_DIV waits for four bit-serial dividers (rpm,
//   speed, wheel circumference, pedal duty) that run side by side, the
//   widest quotient having 24 bits. Sustained: one tick per cycle while idle.
//   Configuration (i_cfg_*): always ready; index 0 sets the tire diameter,
//   index 1 presets the odometer to start_km. Write only while idle.
//   Reset (i_rst_n low, synchronous) clears time, revolution count, rpm,
//   speed, distance and diameter and empties the output register.
//   When the receiver stalls, the result holds in the output register and
//   ticks are still taken; a finished pulse waits until the register frees.
`include "wheel_tachometer_odometer_macros.svh"

module wheel_tachometer_odometer #(
    parameter int REVS_PER_SAMPLE = 5
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [14:0] obstacle_cm, [24:15] throttle_sample, [31:25] zero
    input  logic [31:0] s_axis_tdata,
    // [0] opcode
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [18:0] wheel_rpm, [35:19] speed_kmh, [51:36] odometer_km,
    // [59:52] throttle_duty, [60] collision_warning, [63:61] zero
    output logic [63:0] m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [0:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int PC_W = $clog2(REVS_PER_SAMPLE + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_DIV,
        S_UPD,
        S_WRAP,
        S_OUT
    } t_state;

    t_state           r_state;
    logic [7:0]       r_diam;
    logic [15:0]      r_ms;
    logic [15:0]      r_last;
    logic [PC_W-1:0]  r_pcnt;
    logic [18:0]      r_rpm;
    logic [16:0]      r_speed;
    logic [31:0]      r_km_q;
    logic [16:0]      r_km_r;
    logic [14:0]      r_obst;
    logic [9:0]       r_sample;
    logic [15:0]      r_interval;
    logic             r_meas;
    logic             r_out_valid;
    logic [63:0]      r_out_data;

    logic [7:0]       w_deff;
    logic [23:0]      w_spd_num;
    logic [22:0]      w_spd_den;
    logic [22:0]      w_circ_num;
    logic [16:0]      w_duty_num;
    logic             w_div_start;
    logic             w_busy_rpm;
    logic             w_busy_spd;
    logic             w_busy_circ;
    logic             w_busy_duty;
    logic             w_div_busy;
    logic [18:0]      w_q_rpm;
    logic [23:0]      w_q_spd;
    logic [22:0]      w_q_circ;
    logic [16:0]      w_q_duty;
    logic [16:0]      n_km_sum;
    logic             n_km_carry;
    logic             w_wrap;
    logic             w_borrow;
    logic             w_meas_now;
    logic             w_derate;
    logic [15:0]      w_d10_prod;
    logic [7:0]       w_duty;
    logic             w_warn;

    assign w_deff = (r_diam > wto_pkg::DIAM_MAX) ? wto_pkg::DIAM_MAX : r_diam;

    // operands, formed from registers in S_PREP and latched by the dividers
    assign w_spd_num  = 24'(wto_pkg::SPEED_NUM) * 24'(w_deff);
    assign w_spd_den  = 23'(wto_pkg::SPEED_DEN_MUL) * 23'(r_interval);
    assign w_circ_num = 23'(wto_pkg::CIRC_NUM) * 23'(w_deff);
    assign w_duty_num = 17'(wto_pkg::DUTY_NUM) * 17'(r_sample);

    assign w_div_start = (r_state == S_PREP);
    assign w_div_busy  = w_busy_rpm | w_busy_spd | w_busy_circ | w_busy_duty;

    wto_sdiv #(.N_W(19), .D_W(16)) u_div_rpm (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (wto_pkg::RPM_NUM),
        .i_divisor  (r_interval),
        .o_busy     (w_busy_rpm),
        .o_quotient (w_q_rpm)
    );

    wto_sdiv #(.N_W(24), .D_W(23)) u_div_spd (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_spd_num),
        .i_divisor  (w_spd_den),
        .o_busy     (w_busy_spd),
        .o_quotient (w_q_spd)
    );

    wto_sdiv #(.N_W(23), .D_W(14)) u_div_circ (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_circ_num),
        .i_divisor  (wto_pkg::CIRC_DEN),
        .o_busy     (w_busy_circ),
        .o_quotient (w_q_circ)
    );

    wto_sdiv #(.N_W(17), .D_W(9)) u_div_duty (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_duty_num),
        .i_divisor  (wto_pkg::DUTY_DEN),
        .o_busy     (w_busy_duty),
        .o_quotient (w_q_duty)
    );

    // odometer: add circumference to cm remainder, carry into km
    assign n_km_sum   = r_km_r + 17'(w_q_circ[9:0]);
    assign n_km_carry = (n_km_sum >= wto_pkg::CM_PER_KM);

    // distance reached 2**48 cm: subtract it in km/cm form
    assign w_wrap   = (r_km_q > wto_pkg::KM_WRAP_Q) ||
                      ((r_km_q == wto_pkg::KM_WRAP_Q) && (r_km_r >= wto_pkg::KM_WRAP_R));
    assign w_borrow = (r_km_r < wto_pkg::KM_WRAP_R);

    assign w_meas_now = (r_pcnt >= PC_W'(REVS_PER_SAMPLE));

    // derated duty is the full duty divided by ten
    assign w_derate   = (r_obst < wto_pkg::OBST_DERATE) && (r_speed > wto_pkg::SPEED_DERATE);
    assign w_d10_prod = 16'(wto_pkg::DIV10_MUL) * 16'(w_q_duty[7:0]);
    assign w_duty     = w_derate ? 8'(w_d10_prod >> wto_pkg::DIV10_SHIFT) : w_q_duty[7:0];
    assign w_warn     = (r_obst < wto_pkg::OBST_WARN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_diam      <= '0;
            r_ms        <= '0;
            r_last      <= '0;
            r_pcnt      <= '0;
            r_rpm       <= '0;
            r_speed     <= '0;
            r_km_q      <= '0;
            r_km_r      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        if (s_axis_tuser == wto_pkg::OP_TICK) begin
                            r_ms <= r_ms + 16'd1;
                        end else begin
                            r_obst     <= s_axis_tdata[14:0];
                            r_sample   <= s_axis_tdata[24:15];
                            r_interval <= r_ms - r_last;
                            r_meas     <= w_meas_now;
                            if (w_meas_now) begin
                                r_last <= r_ms;
                                r_pcnt <= PC_W'(1);
                            end else begin
                                r_pcnt <= r_pcnt + PC_W'(1);
                            end
                            r_state <= S_PREP;
                        end
                    end
                end
                S_PREP: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (!w_div_busy) begin
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    if (r_meas) begin
                        if (r_interval == 16'd0) begin
                            r_rpm   <= wto_pkg::RPM_MAX;
                            r_speed <= wto_pkg::SPEED_MAX;
                        end else begin
                            r_rpm   <= w_q_rpm;
                            r_speed <= (w_q_spd > 24'(wto_pkg::SPEED_MAX)) ?
                                       wto_pkg::SPEED_MAX : w_q_spd[16:0];
                        end
                    end
                    r_km_r  <= n_km_carry ? (n_km_sum - wto_pkg::CM_PER_KM) : n_km_sum;
                    r_km_q  <= r_km_q + 32'(n_km_carry);
                    r_state <= S_WRAP;
                end
                S_WRAP: begin
                    if (w_wrap) begin
                        r_km_r <= w_borrow ? (r_km_r + wto_pkg::KM_WRAP_ADJ) :
                                             (r_km_r - wto_pkg::KM_WRAP_R);
                        r_km_q <= r_km_q - wto_pkg::KM_WRAP_Q - 32'(w_borrow);
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    // hold until the output register is free
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_data  <= {3'b000, w_warn, w_duty, r_km_q[15:0], r_speed, r_rpm};
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    wto_pkg::REG_DIAMETER: begin
                        r_diam <= i_cfg_data[7:0];
                    end
                    wto_pkg::REG_START_KM: begin
                        r_km_q <= {16'd0, i_cfg_data};
                        r_km_r <= '0;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    `WTO_ASSERT(a_rem_range, i_clk, i_rst_n, 1'b1, r_km_r < wto_pkg::CM_PER_KM)
    `WTO_ASSERT(a_pcnt_range, i_clk, i_rst_n, 1'b1, r_pcnt <= PC_W'(REVS_PER_SAMPLE))
    `WTO_ASSERT(a_out_limits, i_clk, i_rst_n, m_axis_tvalid, (m_axis_tdata[18:0] <= wto_pkg::RPM_MAX) && (m_axis_tdata[35:19] <= wto_pkg::SPEED_MAX))
    `WTO_ASSERT_NEXT(a_out_load, i_clk, i_rst_n, (r_state == S_OUT) && (!m_axis_tvalid || m_axis_tready), m_axis_tvalid && (r_state == S_IDLE))

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for wheel_tachometer_odometer: a scripted opening, then random
// tick and pulse streams under several diameter / odometer presets, checked per reading.
// Depends on wto_pkg and the wheel_tachometer_odometer RTL.
`timescale 1ns / 100ps

module tb;

    localparam int          REVS            = 5;
    localparam int unsigned RPM_SCALE       = 300000;
    localparam int unsigned RPM_TOP         = 300000;
    localparam int unsigned KMH_SCALE       = 56547;
    localparam int unsigned KMH_TOP         = 113094;
    localparam int unsigned CIRC_SCALE      = 31415;
    localparam int unsigned CIRC_DIV        = 10000;
    localparam int unsigned TIRE_TOP        = 200;
    localparam int unsigned CM_IN_KM        = 100000;
    localparam int unsigned NEAR_CM         = 300;
    localparam int unsigned DERATE_KMH      = 20;
    localparam int unsigned WARN_CM         = 100;
    localparam int          DRAIN_PAUSE     = 40;
    localparam int          QUIET_LIMIT     = 2000;
    localparam int          PHASES          = 8;

    typedef struct packed {
        logic        warn;
        logic [7:0]  duty;
        logic [15:0] km;
        logic [16:0] kmh;
        logic [18:0] rpm;
    } t_reading;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind   kind;
        logic        sel;       // opcode for items, register index for writes
        logic [14:0] obst;
        logic [9:0]  samp;
        logic [15:0] cfg_data;
        logic        typed;
        t_reading    want;
    } t_script_row;

    localparam t_reading NO_READ = '0;
    localparam int ROWS = 21;

    // fields of want, highest first: warn, duty, km, kmh, rpm
    localparam t_script_row SCRIPT [ROWS] = '{
        '{ROW_ITEM, wto_pkg::OP_PULSE,     15'd0,     10'd0,    16'd0,     1'b1,
          '{1'b1, 8'd0,   16'd0, 17'd0,      19'd0}},
        '{ROW_ITEM, wto_pkg::OP_PULSE,     15'd32767, 10'd1023, 16'd0,     1'b1,
          '{1'b0, 8'd255, 16'd0, 17'd0,      19'd0}},
        '{ROW_ITEM, wto_pkg::OP_PULSE,     15'd99,    10'd512,  16'd0,     1'b0, NO_READ},
        '{ROW_ITEM, wto_pkg::OP_PULSE,     15'd100,   10'd511,  16'd0,     1'b0, NO_READ},
        '{ROW_CFG,  wto_pkg::REG_DIAMETER, 15'd0,     10'd0,    16'h3AC8,  1'b0, NO_READ},
        '{ROW_ITEM, wto_pkg::OP_PULSE,     15'd299,   10'd1023, 16'd0,     1'b0, NO_READ},
        // no tick since the last mark: rpm and speed saturate, duty derated
        '{ROW_ITEM, wto_pkg::OP_PULSE,     15'd299,   10'd1023, 16'd0,     1'b1,
          '{1'b0, 8'd25,  16'd0, 17'd113094, 19'd300000}},
        '{ROW_ITEM, wto_pkg::OP_PULSE,     15'd300,   10'd1023, 16'd0,     1'b0, NO_READ},
        '{ROW_ITEM, wto_pkg::OP_TICK,      15'd12345, 10'd777,  16'd0,     1'b0, NO_READ},
        '{ROW_ITEM, wto_pkg::OP_TICK,      15'd0,     10'd0,    16'd0,     1'b0, NO_READ},
        '{ROW_ITEM, wto_pkg::OP_TICK,      15'd32767, 10'd1023, 16'd0,     1'b0, NO_READ},
        '{ROW_ITEM, wto_pkg::OP_PULSE,     15'd500,   10'd256,  16'd0,     1'b0, NO_READ},
        '{ROW_ITEM, wto_pkg::OP_PULSE,     15'd1000,  10'd128,  16'd0,     1'b0, NO_READ},
        '{ROW_ITEM, wto_pkg::OP_PULSE,     15'd18078, 10'd64,   16'd0,     1'b0, NO_READ},
        '{ROW_ITEM, wto_pkg::OP_PULSE,     15'd250,   10'd1000, 16'd0,     1'b0, NO_READ},
        // diameter above the limit clamps to 200
        '{ROW_CFG,  wto_pkg::REG_DIAMETER, 15'd0,     10'd0,    16'hFFFF,  1'b0, NO_READ},
        '{ROW_CFG,  wto_pkg::REG_START_KM, 15'd0,     10'd0,    16'hFFFF,  1'b0, NO_READ},
        '{ROW_ITEM, wto_pkg::OP_PULSE,     15'd200,   10'd700,  16'd0,     1'b0, NO_READ},
        '{ROW_CFG,  wto_pkg::REG_DIAMETER, 15'd0,     10'd0,    16'h5500,  1'b0, NO_READ},
        '{ROW_CFG,  wto_pkg::REG_START_KM, 15'd0,     10'd0,    16'h0000,  1'b0, NO_READ},
        '{ROW_ITEM, wto_pkg::OP_PULSE,     15'd150,   10'd1,    16'd0,     1'b0, NO_READ}
    };

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;
    logic        s_axis_tuser  = wto_pkg::OP_TICK;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic [0:0]  i_cfg_index   = wto_pkg::REG_DIAMETER;
    logic [15:0] i_cfg_data    = '0;

    wheel_tachometer_odometer #(
        .REVS_PER_SAMPLE (REVS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // predictor state
    logic [15:0] clk_ms;
    logic [15:0] mark_ms;
    int unsigned revs_seen;
    logic [18:0] rpm_hold;
    logic [16:0] kmh_hold;
    logic [47:0] travel_cm;
    logic [7:0]  tire_cm;
    logic [15:0] preset_km;

    t_reading readings_due [$];
    t_reading due;
    t_reading seen;
    bit       idle_on = 1'b1;
    int       mismatches    = 0;
    int       readings_seen = 0;
    int       inputs_sent   = 0;
    int       writes_done   = 0;
    int       quiet_cycles  = 0;

    task automatic load_register(input logic idx, input logic [15:0] data);
        if (idx == wto_pkg::REG_DIAMETER) begin
            tire_cm = data[7:0];
        end else if (idx == wto_pkg::REG_START_KM) begin
            preset_km = data;
            travel_cm = 48'(64'(data) * CM_IN_KM);
        end
    endtask

    task automatic tacho_predict(input logic op, input logic [14:0] obst,
                                 input logic [9:0] samp, output bit produced,
                                 output t_reading r);
        int unsigned d;
        int unsigned gap_ms;
        int unsigned kmh;
        int unsigned duty;
        logic [15:0] span;
        d = (tire_cm > TIRE_TOP) ? TIRE_TOP : int'(tire_cm);
        produced = 1'b0;
        r = NO_READ;
        if (op == wto_pkg::OP_TICK) begin
            clk_ms = clk_ms + 16'd1;
        end else begin
            if (revs_seen >= REVS) begin
                span = clk_ms - mark_ms;
                gap_ms = span;
                mark_ms = clk_ms;
                if (gap_ms == 0) begin
                    rpm_hold = 19'(RPM_TOP);
                    kmh_hold = 17'(KMH_TOP);
                end else begin
                    kmh = (KMH_SCALE * d) / (100 * gap_ms);
                    rpm_hold = 19'(RPM_SCALE / gap_ms);
                    kmh_hold = 17'((kmh > KMH_TOP) ? KMH_TOP : kmh);
                end
                revs_seen = 0;
            end
            revs_seen++;
            travel_cm = travel_cm + 48'((CIRC_SCALE * d) / CIRC_DIV);
            if (obst < NEAR_CM && kmh_hold > DERATE_KMH)
                duty = (int'(samp) * 255) / 10230;
            else
                duty = (int'(samp) * 255) / 1023;
            r.rpm  = rpm_hold;
            r.kmh  = kmh_hold;
            r.km   = 16'(travel_cm / CM_IN_KM);
            r.duty = 8'(duty);
            r.warn = (obst < WARN_CM);
            produced = 1'b1;
        end
    endtask

    task automatic push_item(input logic op, input logic [14:0] obst, input logic [9:0] samp,
                             input bit typed, input t_reading want);
        bit       produced;
        t_reading got;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {7'd0, samp, obst};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        tacho_predict(op, obst, samp, produced, got);
        if (produced)
            readings_due.push_back(typed ? want : got);
        inputs_sent++;
    endtask

    task automatic cfg_write(input logic idx, input logic [15:0] data, input bit last);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        load_register(idx, data);
        writes_done++;
        // keep valid up when another write follows right away
        if (last)
            i_cfg_valid <= 1'b0;
    endtask

    // hold the sender until every reading is out, then let the pipeline go quiet
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (readings_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_PAUSE) @(posedge i_clk);
    endtask

    function automatic logic [14:0] pick_obstacle();
        case ($urandom_range(0, 2))
            0:       return 15'($urandom);
            1:       return 15'($urandom_range(0, 400));
            default: return 15'($urandom_range(0, 18078));
        endcase
    endfunction

    task automatic run_phase(input int rounds);
        int burst;
        for (int k = 0; k < rounds; k++) begin
            if ($urandom_range(0, 99) < 85) begin
                // a tick run followed by one revolution
                case ($urandom_range(0, 99))
                    0, 1, 2: burst = $urandom_range(11, 150);
                    default: burst = ($urandom_range(0, 99) < 75) ? $urandom_range(0, 2)
                                                                   : $urandom_range(3, 10);
                endcase
                repeat (burst)
                    push_item(wto_pkg::OP_TICK, 15'($urandom), 10'($urandom), 1'b0, NO_READ);
                push_item(wto_pkg::OP_PULSE, pick_obstacle(), 10'($urandom), 1'b0, NO_READ);
            end else begin
                push_item($urandom_range(0, 1) ? wto_pkg::OP_PULSE : wto_pkg::OP_TICK,
                          pick_obstacle(), 10'($urandom), 1'b0, NO_READ);
            end
        end
    endtask

    initial begin
        clk_ms    = '0;
        mark_ms   = '0;
        revs_seen = 0;
        rpm_hold  = '0;
        kmh_hold  = '0;
        travel_cm = '0;
        tire_cm   = '0;
        preset_km = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < ROWS; r++) begin
            if (SCRIPT[r].kind == ROW_CFG) begin
                if (r == 0 || SCRIPT[r - 1].kind != ROW_CFG)
                    settle();
                cfg_write(SCRIPT[r].sel, SCRIPT[r].cfg_data,
                          (r + 1 >= ROWS) || SCRIPT[r + 1].kind != ROW_CFG);
            end else begin
                push_item(SCRIPT[r].sel, SCRIPT[r].obst, SCRIPT[r].samp,
                          SCRIPT[r].typed, SCRIPT[r].want);
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            logic [7:0]  tire;
            logic [15:0] preset;
            case (ph)
                0:          begin tire = 8'd200; preset = 16'hFFFF;       end
                1:          begin tire = 8'd0;   preset = 16'd0;          end
                2:          begin tire = 8'hFF;  preset = 16'($urandom);  end
                PHASES - 1: begin tire = 8'd1;   preset = 16'hFFFE;       end
                default:    begin tire = 8'($urandom); preset = 16'($urandom); end
            endcase
            settle();
            idle_on = (ph != PHASES - 1);
            cfg_write(wto_pkg::REG_DIAMETER, {8'($urandom), tire}, 1'b0);
            cfg_write(wto_pkg::REG_START_KM, preset, 1'b1);
            // phase 0 carries enough revolutions to roll the odometer over
            run_phase(ph == 0 ? 200 : 15);
        end

        settle();
        $display("Run covered %0d input transfers and %0d register writes; %0d readings checked,",
                 inputs_sent, writes_done, readings_seen);
        $display("including saturation, derating, near-obstacle warning and km roll-over.");
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // receiver: stall in short random bursts while idling is on
    initial begin
        forever begin
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            if (idle_on && $urandom_range(0, 2) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
            end
        end
    end

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (readings_due.size() == 0) begin
                $display("%0t: unexpected reading: expected none, actual %h",
                         $time, m_axis_tdata);
                mismatches++;
            end else begin
                due  = readings_due.pop_front();
                seen = t_reading'(m_axis_tdata[60:0]);
                check_field("wheel_rpm", due.rpm, seen.rpm);
                check_field("speed_kmh", due.kmh, seen.kmh);
                check_field("odometer_km", due.km, seen.km);
                check_field("throttle_duty", due.duty, seen.duty);
                check_field("collision_warning", due.warn, seen.warn);
                readings_seen++;
            end
        end
    end

    // watchdog: give up after a long stretch with no transfer on any channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, %0d readings outstanding",
                     $time, quiet_cycles, readings_due.size());
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
